// File: rtl/arvc_pkg.sv
package arvc_pkg;

    // Address and range geometry
    localparam int unsigned ADDR_W = 64;
    localparam int unsigned SPAN_W = 10;
    localparam logic [ADDR_W-1:0] EMPTY_ADDR = '1;

    // Request action codes
    localparam logic ACT_QUERY = 1'b0;
    localparam logic ACT_INVAL = 1'b1;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
        logic              fill_valid;
    } t_in_req;

    typedef struct packed {
        logic valid_res;
        logic hit;
    } t_out_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_SCAN,
        S_FILL,
        S_HOLD
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic inval;
        logic take_last;
        logic scan_init;
        logic scan_step;
        logic take_scan;
        logic fill;
        logic push;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_hit;
        logic scan_hit;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

    // A range covers start and the 1023 addresses after it; a range that
    // would run past the top of memory covers nothing.
    function automatic logic range_covers(logic [ADDR_W-1:0] start,
                                          logic [ADDR_W-1:0] addr);
        logic [ADDR_W:0] diff;
        logic            past_top;
        diff     = {1'b0, addr} - {1'b0, start};
        past_top = (&start[ADDR_W-1:SPAN_W]) && (|start[SPAN_W-1:0]);
        return !past_top && !diff[ADDR_W] && (diff[ADDR_W-1:SPAN_W] == '0);
    endfunction

endpackage

// File: rtl/arvc_if.sv
interface arvc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/address_range_validity_cache.sv
// Timing: a repeat of the last queried address is answered from the last-query register;
// a hit is answered when the scan reaches the oldest range that covers it; a miss
// after the scan of every held range, read one per cycle, and a fill of a new range.
// A query must finish before the next request is taken; an invalidate leaves the block ready.
// Reset: synchronous, active low; empties the cache and the last-query register.
// The range store has no clearing pass; requests are taken as soon as reset ends.
module address_range_validity_cache import arvc_pkg::*; #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    arvc_if.sink   i_req,
    arvc_if.source o_rsp
);

    t_dp_cmd  cmd;
    t_dp_sts  sts;
    t_in_req  req;
    t_out_rsp rsp;
    logic     req_ready;
    logic     rsp_valid;

    assign req         = i_req.data;
    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;
    assign o_rsp.data  = rsp;

    // Sequence each request
    arvc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_action (req.action),
        .i_sts        (sts),
        .o_req_ready  (req_ready),
        .o_cmd        (cmd)
    );

    // Hold the ranges, scan them and register the result
    arvc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_address    (req.address),
        .i_fill_valid (req.fill_valid),
        .i_out_ready  (o_rsp.ready),
        .o_sts        (sts),
        .o_out_valid  (rsp_valid),
        .o_out_data   (rsp)
    );

endmodule

// File: rtl/arvc_ctrl.sv
module arvc_ctrl import arvc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  logic    i_req_action,
    input  t_dp_sts i_sts,
    output logic    o_req_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && i_req_action == ACT_QUERY) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = i_sts.last_hit ? S_HOLD : S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_hit) begin
                    n_state = S_HOLD;
                end else if (i_sts.scan_done) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load  = (i_req_action == ACT_QUERY);
                    o_cmd.inval = (i_req_action == ACT_INVAL);
                end
            end
            S_LAST: begin
                o_cmd.take_last = i_sts.last_hit;
                o_cmd.scan_init = !i_sts.last_hit;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.take_scan = i_sts.scan_hit;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
            end
            S_HOLD: begin
                o_cmd.push = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: rtl/arvc_dp.sv
module arvc_dp import arvc_pkg::*; #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [ADDR_W-1:0] i_address,
    input  logic              i_fill_valid,
    input  logic              i_out_ready,
    output t_dp_sts           o_sts,
    output logic              o_out_valid,
    output t_out_rsp          o_out_data
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(ENTRIES - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(ENTRIES);
    localparam logic [CW:0]   ENT_EXT   = (CW + 1)'(ENTRIES);

    // Range store: start address above, validity bit in bit 0
    logic [ADDR_W:0]   r_mem [ENTRIES];

    logic [ADDR_W-1:0] r_addr;
    logic              r_fill;
    logic [ADDR_W-1:0] r_last_addr;
    logic              r_last_valid;
    logic [CW-1:0]     r_count;
    logic [IW-1:0]     r_oldest;
    logic [IW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_issue_cnt;
    logic              r_rd_vld;
    logic [ADDR_W:0]   r_rd_data;
    logic              r_res;
    logic              r_res_hit;
    logic              r_out_vld;
    logic              r_out_res;
    logic              r_out_hit;

    logic [IW-1:0]     n_rd_ptr;
    logic [IW-1:0]     n_oldest;
    logic [CW:0]       slot_sum;
    logic [IW-1:0]     fill_slot;
    logic              full;
    logic              issue_more;

    // Advance pointers with wrap at the last slot
    assign n_rd_ptr   = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
    assign n_oldest   = (r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1;
    assign full       = (r_count == FULL_CNT);
    assign issue_more = (r_issue_cnt != r_count);

    // Pick the slot for a new range: next free one, or the oldest when full
    assign slot_sum = {1'b0, r_count} + (CW + 1)'(r_oldest);
    always_comb begin
        if (full) begin
            fill_slot = r_oldest;
        end else if (slot_sum >= ENT_EXT) begin
            fill_slot = IW'(slot_sum - ENT_EXT);
        end else begin
            fill_slot = IW'(slot_sum);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_addr  <= EMPTY_ADDR;
            r_last_valid <= 1'b0;
            r_count      <= '0;
            r_oldest     <= '0;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cmd.inval) begin
                r_count     <= '0;
                r_oldest    <= '0;
                r_last_addr <= EMPTY_ADDR;
            end
            if (i_cmd.take_scan) begin
                r_last_addr  <= r_addr;
                r_last_valid <= r_rd_data[0];
            end
            if (i_cmd.fill) begin
                r_last_addr  <= r_addr;
                r_last_valid <= r_fill;
                if (full) begin
                    r_oldest <= n_oldest;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.scan_init) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= issue_more;
            end
            if (i_cmd.push) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Request capture, scan counters and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_address;
            r_fill <= i_fill_valid;
        end
        if (i_cmd.scan_init) begin
            r_rd_ptr    <= r_oldest;
            r_issue_cnt <= '0;
        end else if (i_cmd.scan_step && issue_more) begin
            r_rd_ptr    <= n_rd_ptr;
            r_issue_cnt <= r_issue_cnt + 1'b1;
        end
        if (i_cmd.take_last) begin
            r_res     <= r_last_valid;
            r_res_hit <= 1'b1;
        end else if (i_cmd.take_scan) begin
            r_res     <= r_rd_data[0];
            r_res_hit <= 1'b1;
        end else if (i_cmd.fill) begin
            r_res     <= r_fill;
            r_res_hit <= 1'b0;
        end
        if (i_cmd.push) begin
            r_out_res <= r_res;
            r_out_hit <= r_res_hit;
        end
    end

    // Range store: write on fill, registered read during the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_mem[fill_slot] <= {r_addr, r_fill};
        end
        if (i_cmd.scan_step && issue_more) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // Status
    assign o_sts.last_hit  = (r_last_addr != EMPTY_ADDR) && (r_addr == r_last_addr);
    assign o_sts.scan_hit  = r_rd_vld && range_covers(r_rd_data[ADDR_W:1], r_addr);
    assign o_sts.scan_done = !r_rd_vld && !issue_more;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid          = r_out_vld;
    assign o_out_data.valid_res = r_out_res;
    assign o_out_data.hit       = r_out_hit;

endmodule

// File: rtl/arvc_chk.sv
module arvc_chk import arvc_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_req_valid,
    input logic     i_req_ready,
    input logic     i_req_action,
    input logic     i_rsp_valid,
    input logic     i_rsp_ready,
    input t_out_rsp i_rsp_data
);

    // A stalled response stays valid
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response keeps its payload
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_data))
        else $error("response payload changed while stalled");

    // A query keeps the block busy on the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_action == ACT_QUERY |=> !i_req_ready)
        else $error("request taken while a query is in flight");

    // An invalidate completes at once and leaves the block ready
    a_inval_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_action == ACT_INVAL |=> i_req_ready)
        else $error("invalidate left the block busy");

endmodule

bind address_range_validity_cache arvc_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_action (i_req.data.action),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_data   (o_rsp.data)
);

// File: dv/arvc_answer_checker.sv
module arvc_answer_checker import arvc_pkg::*; #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  logic     i_req_ready,
    input  t_in_req  i_req_data,
    input  logic     i_rsp_valid,
    input  logic     i_rsp_ready,
    input  t_out_rsp i_rsp_data,
    output int       o_fail_count,
    output int       o_pending
);

    localparam logic [ADDR_W-1:0] RANGE_SPAN = 64'd1023;

    typedef struct {
        logic [ADDR_W-1:0] address;
        t_out_rsp          answer;
    } t_pending_answer;

    // Shadow copy of the cache contents
    logic [ADDR_W-1:0] range_base [ENTRIES];
    logic              range_ok   [ENTRIES];
    int unsigned       ranges_held;
    int unsigned       oldest_slot;
    logic [ADDR_W-1:0] recent_addr;
    logic              recent_ok;

    t_pending_answer   pending_answers[$];
    t_pending_answer   due;
    int                fail_total = 0;

    // A range covering the top of memory only counts if all 1024 addresses fit
    function automatic logic base_covers(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] addr);
        if (base > EMPTY_ADDR - RANGE_SPAN)
            return 1'b0;
        return (addr >= base) && ((addr - base) <= RANGE_SPAN);
    endfunction

    // Answer one query and update the shadow cache the way the block should
    function automatic t_out_rsp lookup_validity(logic [ADDR_W-1:0] addr, logic fill);
        t_out_rsp    ans;
        int unsigned slot;
        logic        found;
        ans   = '0;
        found = 1'b0;
        if (recent_addr != EMPTY_ADDR && addr == recent_addr) begin
            ans.valid_res = recent_ok;
            ans.hit       = 1'b1;
            return ans;
        end
        // oldest range wins
        for (int unsigned i = 0; i < ranges_held; i++) begin
            slot = (oldest_slot + i) % ENTRIES;
            if (!found && base_covers(range_base[slot], addr)) begin
                found         = 1'b1;
                ans.valid_res = range_ok[slot];
                ans.hit       = 1'b1;
            end
        end
        // on a miss insert a new range, evicting the oldest when full
        if (!found) begin
            if (ranges_held == ENTRIES) begin
                slot        = oldest_slot;
                oldest_slot = (oldest_slot + 1) % ENTRIES;
            end else begin
                slot        = (oldest_slot + ranges_held) % ENTRIES;
                ranges_held = ranges_held + 1;
            end
            range_base[slot] = addr;
            range_ok[slot]   = fill;
            ans.valid_res    = fill;
            ans.hit          = 1'b0;
        end
        recent_addr = addr;
        recent_ok   = ans.valid_res;
        return ans;
    endfunction

    // Compare responses, then predict from the request accepted at this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ranges_held = 0;
            oldest_slot = 0;
            recent_addr = EMPTY_ADDR;
            recent_ok   = 1'b0;
            pending_answers.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_answers.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected response: valid_res=%0b hit=%0b",
                                 i_rsp_data.valid_res, i_rsp_data.hit);
                end else begin
                    due = pending_answers.pop_front();
                    if (i_rsp_data.valid_res !== due.answer.valid_res ||
                        i_rsp_data.hit !== due.answer.hit) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("mismatch %h: expected %0b/%0b, got %0b/%0b (valid_res/hit)",
                                     due.address, due.answer.valid_res, due.answer.hit,
                                     i_rsp_data.valid_res, i_rsp_data.hit);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req_data.action == ACT_INVAL) begin
                    ranges_held = 0;
                    oldest_slot = 0;
                    recent_addr = EMPTY_ADDR;
                end else begin
                    due.address = i_req_data.address;
                    due.answer  = lookup_validity(i_req_data.address, i_req_data.fill_valid);
                    pending_answers.push_back(due);
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_answers.size();
    end

endmodule

// File: dv/tb_address_range_validity_cache.sv
module tb_address_range_validity_cache;
    import arvc_pkg::*;

    localparam int unsigned CACHE_DEPTH     = 64;
    localparam int unsigned STALL_LIMIT     = 4000;
    localparam int unsigned RANDOM_REQUESTS = 2000;
    localparam int unsigned POOL_SIZE       = 96;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    arvc_if #(.T(t_in_req))  req_if ();
    arvc_if #(.T(t_out_rsp)) rsp_if ();

    int                tx_idle_pct;
    int                rx_idle_pct;
    int                fail_count;
    int                pending_count;
    int                stall_cycles;
    logic [ADDR_W-1:0] base_pool [POOL_SIZE];
    logic [ADDR_W-1:0] last_queried;

    always #5 i_clk = ~i_clk;

    address_range_validity_cache #(.ENTRIES(CACHE_DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    arvc_answer_checker #(.ENTRIES(CACHE_DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_if.valid),
        .i_req_ready  (req_if.ready),
        .i_req_data   (req_if.data),
        .i_rsp_valid  (rsp_if.valid),
        .i_rsp_ready  (rsp_if.ready),
        .i_rsp_data   (rsp_if.data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Stall the response side at random
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one request and hold it until accepted
    task automatic send_request(input logic action, input logic [ADDR_W-1:0] address,
                                input logic fill);
        t_in_req req;
        req.action     = action;
        req.address    = address;
        req.fill_valid = fill;
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= req;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        if (action == ACT_QUERY)
            last_queried = address;
    endtask

    function automatic logic [ADDR_W-1:0] random_addr();
        return {$urandom, $urandom};
    endfunction

    // Mostly queries around known range bases, so ranges hit, miss and get evicted
    task automatic send_random_request();
        int                pick;
        int unsigned       idx;
        logic [ADDR_W-1:0] addr;
        logic              fill;
        fill = 1'($urandom_range(1));
        if ($urandom_range(199) == 0) begin
            send_request(ACT_INVAL, random_addr(), fill);
            return;
        end
        pick = $urandom_range(99);
        idx  = $urandom_range(POOL_SIZE - 1);
        if (pick < 15) begin
            addr = last_queried;
        end else if (pick < 60) begin
            case ($urandom_range(9))
                0:       addr = base_pool[idx] + 1024 + $urandom_range(15);
                1:       addr = base_pool[idx] - $urandom_range(16, 1);
                default: addr = base_pool[idx] + $urandom_range(1023);
            endcase
        end else if (pick < 70) begin
            addr = random_addr();
        end else if (pick < 77) begin
            addr = EMPTY_ADDR - $urandom_range(2100);
        end else if (pick < 80) begin
            addr = EMPTY_ADDR;
        end else if (pick < 88) begin
            addr = ADDR_W'($urandom_range(4096));
        end else begin
            base_pool[idx] = random_addr();
            addr           = base_pool[idx];
        end
        send_request(ACT_QUERY, addr, fill);
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        tx_idle_pct  = 13;
        rx_idle_pct  = 77;
        last_queried = '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            case (i % 4)
                0:       base_pool[i] = EMPTY_ADDR - $urandom_range(3000);
                1:       base_pool[i] = ADDR_W'($urandom_range(65535));
                default: base_pool[i] = random_addr();
            endcase
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // miss, then repeat of the last query, then hit at the far end of the range
        send_request(ACT_QUERY, 64'd0, 1'b1);
        send_request(ACT_QUERY, 64'd0, 1'b0);
        send_request(ACT_QUERY, 64'd1023, 1'b0);
        send_request(ACT_QUERY, 64'd1024, 1'b0);
        // all-ones address never matches the last-query register
        send_request(ACT_QUERY, EMPTY_ADDR, 1'b1);
        send_request(ACT_QUERY, EMPTY_ADDR, 1'b0);
        // highest range that still counts, then hits at the top address
        send_request(ACT_QUERY, EMPTY_ADDR - 1023, 1'b1);
        send_request(ACT_QUERY, EMPTY_ADDR, 1'b0);
        send_request(ACT_QUERY, EMPTY_ADDR, 1'b1);
        // range that would run past the top of memory matches nothing
        send_request(ACT_INVAL, EMPTY_ADDR, 1'b1);
        send_request(ACT_QUERY, EMPTY_ADDR - 500, 1'b1);
        send_request(ACT_QUERY, EMPTY_ADDR - 499, 1'b0);
        send_request(ACT_QUERY, 64'h8000_0000_0000_0000, 1'b1);
        send_request(ACT_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_request(ACT_QUERY, 64'h5555_5555_5555_5555, 1'b1);
        // empty cache, then an address just below a range start
        send_request(ACT_INVAL, 64'd0, 1'b0);
        send_request(ACT_QUERY, 64'd5, 1'b0);
        send_request(ACT_QUERY, 64'd0, 1'b1);
        send_request(ACT_QUERY, 64'd5, 1'b1);

        // random traffic under three idle profiles
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 13; rx_idle_pct = 77; end
                1:       begin tx_idle_pct = 77; rx_idle_pct = 13; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            repeat (RANDOM_REQUESTS / 3) send_random_request();
        end
        req_if.valid <= 1'b0;

        // drain outstanding responses, then watch for stray ones
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (CACHE_DEPTH + 8) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
